// File: design/rftb_pkg.sv
// rftb_pkg: shared codes, widths and controller/datapath interface structs
// for the ring finger table builder. No dependencies; used by every module.
`default_nettype none

package rftb_pkg;

	// opcodes carried in s_tuser
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_DUP   = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_RANGE = 3'd3;
	localparam logic [2:0] ST_RANK  = 3'd4;

	localparam int unsigned ID_W      = 16;
	localparam int unsigned RANK_W    = 5;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned FIDX_W    = 4;
	localparam int unsigned OPC_W     = 2;
	localparam int unsigned KEYCFG_W  = 5;
	localparam logic [4:0]  KEY_BITS_RESET = 5'd6;
	localparam int unsigned S_DATA_W  = 24;
	localparam int unsigned M_DATA_W  = 48;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_INC,
		PTR_DEC,
		PTR_TOP
	} ptr_op_t;

	typedef struct packed {
		logic          latch;
		logic          clear_cnt;
		ptr_op_t       ptr_op;
		logic          save_pos;
		logic          shift_wr;
		logic          insert;
		logic          tgt_init;
		logic          tgt_step;
		logic          emit;
		logic          emit_finger;
		logic [2:0]    status;
	} dp_cmd_t;

	typedef struct packed {
		logic range_err;
		logic rank_bad;
		logic scan_end;
		logic scan_eq;
		logic scan_gt;
		logic full;
		logic pos_at_end;
		logic shift_done;
		logic hit;
		logic last_finger;
		logic tgt_wraps;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: design/rftb_datapath.sv
// rftb_datapath: sorted id table, rank-ordered id table, scan pointer,
// finger target unit and output register. Uses rftb_pkg; driven by rftb_ctrl.
`default_nettype none

module rftb_datapath #(
	parameter int unsigned MAX_NODES    = 16,
	parameter int unsigned MAX_KEY_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [rftb_pkg::KEYCFG_W-1:0]     cfg_wdata,
	input  wire [rftb_pkg::S_DATA_W-1:0]     s_tdata,
	input  rftb_pkg::dp_cmd_t                cmd,
	output rftb_pkg::dp_stat_t               stat,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [rftb_pkg::M_DATA_W-1:0]    m_tdata,
	output logic                             m_tlast
);

	localparam int unsigned ID_W = rftb_pkg::ID_W;
	localparam int unsigned IW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned CW   = $clog2(MAX_NODES + 1);
	localparam int unsigned TW   = (MAX_KEY_BITS > ID_W) ? MAX_KEY_BITS : ID_W;
	localparam int unsigned JW   = $clog2(MAX_KEY_BITS);
	localparam int unsigned KBW  = $clog2(MAX_KEY_BITS + 1);
	localparam int unsigned EW   = CW + ID_W;

	logic [rftb_pkg::KEYCFG_W-1:0] key_bits_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 ptr_q;
	logic [CW-1:0]                 ptr_d;
	logic [CW-1:0]                 ptr_p1;
	logic [CW-1:0]                 pos_q;
	logic [ID_W-1:0]               id_q;
	logic [rftb_pkg::RANK_W-1:0]   rank_q;
	logic [ID_W-1:0]               base_q;
	logic [EW-1:0]                 rd_q;
	logic [EW-1:0]                 first_q;
	logic [TW-1:0]                 tgt_q;
	logic [JW-1:0]                 j_q;
	logic                          m_tvalid_q;
	logic [rftb_pkg::M_DATA_W-1:0] m_tdata_q;
	logic                          m_tlast_q;

	// sorted table entry: {rank, id}
	logic [EW-1:0]   sorted_mem [MAX_NODES];
	logic [ID_W-1:0] ibr_mem    [MAX_NODES];

	logic [ID_W-1:0]             s_id;
	logic [rftb_pkg::RANK_W-1:0] s_rank;
	logic [31:0]                 rank_m1;
	logic [KBW-1:0]              kb_eff;
	logic [TW-1:0]               one_tw;
	logic [TW-1:0]               mask;
	logic [TW-1:0]               tgt_first;
	logic [TW-1:0]               tgt_next;
	logic [JW:0]                 jn;
	logic [ID_W-1:0]             rd_id;
	logic [EW-1:0]               succ;
	logic                        last_finger;

	assign s_id    = s_tdata[15:0];
	assign s_rank  = s_tdata[20:16];
	assign rank_m1 = 32'(s_rank) - 32'd1;
	assign rd_id   = rd_q[ID_W-1:0];
	assign ptr_p1  = ptr_q + CW'(1);

	// out-of-range key widths clamp to the legal span
	always_comb begin
		if (key_bits_q == '0) begin
			kb_eff = KBW'(1);
		end else if (32'(key_bits_q) > MAX_KEY_BITS) begin
			kb_eff = KBW'(MAX_KEY_BITS);
		end else begin
			kb_eff = KBW'(key_bits_q);
		end
	end

	assign one_tw      = TW'(1);
	assign mask        = (one_tw << kb_eff) - one_tw;
	assign jn          = (JW+1)'(j_q) + (JW+1)'(1);
	assign tgt_first   = (TW'(base_q) + one_tw) & mask;
	assign tgt_next    = (TW'(base_q) + (one_tw << jn)) & mask;
	assign last_finger = (32'(j_q) + 32'd1) == 32'(kb_eff);
	// past the largest id the successor wraps to the smallest one
	assign succ        = (ptr_q == cnt_q) ? first_q : rd_q;

	always_comb begin
		stat.range_err   = (id_q >> kb_eff) != '0;
		stat.rank_bad    = (rank_q == '0) || (32'(rank_q) > 32'(cnt_q));
		stat.scan_end    = ptr_q == cnt_q;
		stat.scan_eq     = rd_id == id_q;
		stat.scan_gt     = rd_id > id_q;
		stat.full        = cnt_q == CW'(MAX_NODES);
		stat.pos_at_end  = pos_q == cnt_q;
		stat.shift_done  = ptr_q == pos_q;
		stat.hit         = (ptr_q == cnt_q) || (TW'(rd_id) >= tgt_q);
		stat.last_finger = last_finger;
		// targets climb until they pass the top of the ring, then restart low
		stat.tgt_wraps   = tgt_next < tgt_q;
		stat.out_free    = !m_tvalid_q || m_tready;
	end

	always_comb begin
		case (cmd.ptr_op)
			rftb_pkg::PTR_HOLD: ptr_d = ptr_q;
			rftb_pkg::PTR_ZERO: ptr_d = '0;
			rftb_pkg::PTR_INC:  ptr_d = ptr_p1;
			rftb_pkg::PTR_DEC:  ptr_d = ptr_q - CW'(1);
			rftb_pkg::PTR_TOP:  ptr_d = cnt_q - CW'(1);
			default:            ptr_d = ptr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bits_q <= rftb_pkg::KEY_BITS_RESET;
			cnt_q      <= '0;
			ptr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				key_bits_q <= cfg_wdata;
			end
			if (cmd.clear_cnt) begin
				cnt_q <= '0;
			end else if (cmd.insert) begin
				cnt_q <= cnt_q + CW'(1);
			end
			ptr_q <= ptr_d;
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// tables: one write port each, registered reads
	always_ff @(posedge clk) begin
		if (cmd.shift_wr) begin
			sorted_mem[ptr_p1[IW-1:0]] <= rd_q;
		end else if (cmd.insert) begin
			sorted_mem[pos_q[IW-1:0]] <= {cnt_q + CW'(1), id_q};
		end
		if (cmd.insert) begin
			ibr_mem[cnt_q[IW-1:0]] <= id_q;
		end
		rd_q <= sorted_mem[ptr_d[IW-1:0]];
		if (cmd.latch) begin
			base_q <= ibr_mem[rank_m1[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			id_q   <= s_id;
			rank_q <= s_rank;
		end
		if (cmd.save_pos) begin
			pos_q <= ptr_q;
		end
		if (ptr_q == '0) begin
			first_q <= rd_q;
		end
		if (cmd.tgt_init) begin
			tgt_q <= tgt_first;
			j_q   <= '0;
		end else if (cmd.tgt_step) begin
			tgt_q <= tgt_next;
			j_q   <= j_q + JW'(1);
		end
		if (cmd.emit) begin
			if (cmd.emit_finger) begin
				m_tdata_q <= {4'd0, 5'(succ[EW-1:ID_W]), succ[ID_W-1:0],
					16'(tgt_q), 4'(j_q), rftb_pkg::ST_OK};
				m_tlast_q <= last_finger;
			end else begin
				m_tdata_q <= {45'd0, cmd.status};
				m_tlast_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_NODES)
		else $error("node count past table depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid_q || m_tready))
		else $error("result word overwritten before it was taken");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> (32'(cnt_q) < MAX_NODES))
		else $error("insert into a full table");

	a_shift_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_wr |-> (ptr_q >= pos_q && ptr_q < cnt_q && !cmd.insert))
		else $error("shift outside the occupied span");

endmodule

`default_nettype wire

// File: design/rftb_ctrl.sv
// rftb_ctrl: sequencer for clear, load (scan, shift, insert) and finger query.
// Uses rftb_pkg; drives rftb_datapath through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module rftb_ctrl (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire [rftb_pkg::OPC_W-1:0]     s_opcode,
	input  rftb_pkg::dp_stat_t            stat,
	output rftb_pkg::dp_cmd_t             cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LCHECK,
		S_LSCAN,
		S_LDECIDE,
		S_LSHIFT,
		S_LINSERT,
		S_QCHECK,
		S_QSEARCH,
		S_RESP
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [2:0] resp_code_q;
	logic [2:0] code_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.ptr_op = rftb_pkg::PTR_HOLD;
		state_d    = state_q;
		code_d     = resp_code_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.latch  = 1'b1;
					cmd.ptr_op = rftb_pkg::PTR_ZERO;
					case (s_opcode)
						rftb_pkg::OP_CLEAR: begin
							cmd.clear_cnt = 1'b1;
							code_d        = rftb_pkg::ST_OK;
							state_d       = S_RESP;
						end
						rftb_pkg::OP_LOAD:  state_d = S_LCHECK;
						rftb_pkg::OP_QUERY: state_d = S_QCHECK;
						default:            state_d = S_IDLE;
					endcase
				end
			end
			S_LCHECK: begin
				if (stat.range_err) begin
					code_d  = rftb_pkg::ST_RANGE;
					state_d = S_RESP;
				end else begin
					state_d = S_LSCAN;
				end
			end
			S_LSCAN: begin
				if (stat.scan_end) begin
					cmd.save_pos = 1'b1;
					state_d      = S_LDECIDE;
				end else if (stat.scan_eq) begin
					code_d  = rftb_pkg::ST_DUP;
					state_d = S_RESP;
				end else if (stat.scan_gt) begin
					cmd.save_pos = 1'b1;
					state_d      = S_LDECIDE;
				end else begin
					cmd.ptr_op = rftb_pkg::PTR_INC;
				end
			end
			S_LDECIDE: begin
				if (stat.full) begin
					code_d  = rftb_pkg::ST_FULL;
					state_d = S_RESP;
				end else if (stat.pos_at_end) begin
					state_d = S_LINSERT;
				end else begin
					cmd.ptr_op = rftb_pkg::PTR_TOP;
					state_d    = S_LSHIFT;
				end
			end
			S_LSHIFT: begin
				// move one entry up per cycle, top down to the insert slot
				cmd.shift_wr = 1'b1;
				if (stat.shift_done) begin
					state_d = S_LINSERT;
				end else begin
					cmd.ptr_op = rftb_pkg::PTR_DEC;
				end
			end
			S_LINSERT: begin
				cmd.insert = 1'b1;
				code_d     = rftb_pkg::ST_OK;
				state_d    = S_RESP;
			end
			S_QCHECK: begin
				if (stat.rank_bad) begin
					code_d  = rftb_pkg::ST_RANK;
					state_d = S_RESP;
				end else begin
					cmd.tgt_init = 1'b1;
					state_d      = S_QSEARCH;
				end
			end
			S_QSEARCH: begin
				if (stat.hit) begin
					if (stat.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_finger = 1'b1;
						cmd.status      = rftb_pkg::ST_OK;
						if (stat.last_finger) begin
							state_d = S_IDLE;
						end else begin
							cmd.tgt_step = 1'b1;
							cmd.ptr_op   = stat.tgt_wraps ? rftb_pkg::PTR_ZERO
								: rftb_pkg::PTR_HOLD;
						end
					end
				end else begin
					cmd.ptr_op = rftb_pkg::PTR_INC;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.emit   = 1'b1;
					cmd.status = resp_code_q;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			resp_code_q <= rftb_pkg::ST_OK;
		end else begin
			state_q     <= state_d;
			resp_code_q <= code_d;
		end
	end

endmodule

`default_nettype wire

// File: design/ring_finger_table_builder_top.sv
// ring_finger_table_builder_top: top level of the ring finger table builder.
// Joins rftb_ctrl and rftb_datapath; uses rftb_pkg.
//
// Usage: one input word on the s_ side carries an opcode in s_tuser (clear,
// load, query) and node id / node rank in s_tdata. Clear and load answer with
// a single status word; a query answers with one word per finger, one per
// effective key bit, m_tlast marking the final one. An unknown rank answers
// with a single status word. Opcode three is dropped without an answer.
// key_bits is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle, as the block does not enforce this. A load
// scans and shifts the sorted table; a query walks it, since it has one
// read port, one entry a cycle while no finger waits on m_tready, at most
// twice per query.
// One word is in flight at a time; s_tready is high only between words.
// Results sit in an output register: a finished word waits there while the
// next input word is taken, and a stalled m_tready holds the finger walk.
// Reset empties the ring and sets key_bits to 6; no clearing pass is needed.
`default_nettype none

module ring_finger_table_builder_top #(
	parameter int unsigned MAX_NODES    = 16,
	parameter int unsigned MAX_KEY_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [4:0]  cfg_wdata,  // key_bits
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,    // node_id[15:0], node_rank[20:16], zero pad
	input  wire  [1:0]  s_tuser,    // opcode[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,    // status[2:0], finger_index[6:3],
	                                // target_key[22:7], successor_id[38:23],
	                                // successor_rank[43:39], zero pad
	output logic        m_tlast     // last
);

	rftb_pkg::dp_cmd_t  cmd;
	rftb_pkg::dp_stat_t stat;

	rftb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_opcode (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	rftb_datapath #(
		.MAX_NODES    (MAX_NODES),
		.MAX_KEY_BITS (MAX_KEY_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire
